FILE: rtl/sfta_pkg.sv
// ----------------------------------------------------------------------------
// sfta_pkg
// Shared types and constants for the strip/fan triangle assembler.
// ----------------------------------------------------------------------------
package sfta_pkg;

  // Default width of the running vertex counter
  localparam int unsigned INDEX_BITS_DEFAULT = 16;

  // Command word and output index widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned FIELD_W = 15;
  localparam int unsigned IDX_W = 16;

  // Triangle forms once this many vertices of a primitive have gone by
  localparam logic [IDX_W-1:0] TRI_START = IDX_W'(2);

  // One result word
  typedef struct packed {
    logic                     vertex_valid;
    logic [IDX_W-1:0]         vertex_index;
    logic [FIELD_W-1:0]       position_index;
    logic [FIELD_W-1:0]       normal_index;
    logic signed [WORD_W-1:0] tex_s;
    logic signed [WORD_W-1:0] tex_t;
    logic                     triangle_valid;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
    logic                     mesh_end;
    logic                     index_overflow;
  } sfta_result_t;

endpackage

FILE: rtl/sfta_in_stage.sv
// ----------------------------------------------------------------------------
// sfta_in_stage
// Input register for command words.
// ----------------------------------------------------------------------------
module sfta_in_stage import sfta_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WORD_W-1:0] in_word,
  input  logic                     adv,
  output logic                     word_valid,
  output logic signed [WORD_W-1:0] word
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [WORD_W-1:0] word_r;

  // Room when empty or when the held word moves on this cycle
  assign in_ready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

FILE: rtl/sfta_core.sv
// ----------------------------------------------------------------------------
// sfta_core
// Header/vertex decode, vertex counter and triangle corner arithmetic.
// ----------------------------------------------------------------------------
module sfta_core import sfta_pkg::*; #(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic signed [WORD_W-1:0] word,
  output logic                     res_valid,
  output sfta_result_t             res
);

  typedef enum logic [1:0] {
    PH_POS,
    PH_NORM,
    PH_S,
    PH_T
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [WORD_W-1:0]         vleft_r, vleft_nxt;
  logic                      fan_r, fan_nxt;
  logic [IDX_W-1:0]          vip_r, vip_nxt;
  logic [INDEX_BITS-1:0]     cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]        pos_r, pos_nxt;
  logic [FIELD_W-1:0]        nrm_r, nrm_nxt;
  logic signed [WORD_W-1:0]  s_r, s_nxt;
  logic                      ovf_r, ovf_nxt;

  logic [31:0]               cnt_ext;
  logic [IDX_W-1:0]          idx;
  logic                      at_limit;
  logic [WORD_W-1:0]         w;

  assign w        = word;
  assign cnt_ext  = 32'(cnt_r);
  assign idx      = cnt_ext[IDX_W-1:0];
  assign at_limit = (cnt_r == {INDEX_BITS{1'b1}});

  // Next state and result for the held word
  always_comb begin
    phase_nxt = phase_r;
    vleft_nxt = vleft_r;
    fan_nxt   = fan_r;
    vip_nxt   = vip_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    nrm_nxt   = nrm_r;
    s_nxt     = s_r;
    ovf_nxt   = ovf_r;
    res_valid = 1'b0;
    res       = '0;

    if (vleft_r == '0) begin
      // header word
      if (w == '0) begin
        res_valid          = 1'b1;
        res.mesh_end       = 1'b1;
        res.index_overflow = ovf_r;
      end else begin
        fan_nxt   = w[WORD_W-1];
        vleft_nxt = w[WORD_W-1] ? (WORD_W'(0) - w) : w;
        vip_nxt   = '0;
        phase_nxt = PH_POS;
      end
    end else begin
      unique case (phase_r)
        PH_POS: begin
          pos_nxt   = w[FIELD_W-1:0];
          phase_nxt = PH_NORM;
        end
        PH_NORM: begin
          nrm_nxt   = w[FIELD_W-1:0];
          phase_nxt = PH_S;
        end
        PH_S: begin
          s_nxt     = word;
          phase_nxt = PH_T;
        end
        PH_T: begin
          // last word: emit vertex, advance saturating counter
          phase_nxt = PH_POS;
          if (at_limit) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (vip_r != {IDX_W{1'b1}}) begin
            vip_nxt = vip_r + 1'b1;
          end
          vleft_nxt = vleft_r - 1'b1;

          res_valid          = 1'b1;
          res.vertex_valid   = 1'b1;
          res.vertex_index   = idx;
          res.position_index = pos_r;
          res.normal_index   = nrm_r;
          res.tex_s          = s_r;
          res.tex_t          = word;
          res.index_overflow = ovf_nxt;
          if (vip_r >= TRI_START) begin
            res.triangle_valid = 1'b1;
            res.corner_c       = idx;
            if (fan_r) begin
              res.corner_a = idx - vip_r;
              res.corner_b = idx - IDX_W'(1);
            end else if (!vip_r[0]) begin
              res.corner_a = idx - IDX_W'(2);
              res.corner_b = idx - IDX_W'(1);
            end else begin
              res.corner_a = idx - IDX_W'(1);
              res.corner_b = idx - IDX_W'(2);
            end
          end
        end
        default: begin
          phase_nxt = PH_POS;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POS;
      vleft_r <= '0;
      fan_r   <= 1'b0;
      vip_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
      nrm_r   <= '0;
      s_r     <= '0;
      ovf_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      vleft_r <= vleft_nxt;
      fan_r   <= fan_nxt;
      vip_r   <= vip_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      nrm_r   <= nrm_nxt;
      s_r     <= s_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

FILE: rtl/sfta_out_stage.sv
// ----------------------------------------------------------------------------
// sfta_out_stage
// Result register in front of the output channel.
// ----------------------------------------------------------------------------
module sfta_out_stage import sfta_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  sfta_result_t load_res,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         full,
  output sfta_result_t res
);

  logic         valid_r;
  logic         valid_nxt;
  sfta_result_t res_r;

  // Load only happens when empty or draining this cycle
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign full      = valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/strip_fan_triangle_assembler.sv
// ----------------------------------------------------------------------------
// strip_fan_triangle_assembler
// Turns strip/fan command words into vertex records and triangle-list corners.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_cmd_word) takes one 16-bit command
//   word per transfer: a header count (positive strip, negative fan, zero
//   mesh end) followed by four words per vertex (position, normal, s, t).
//   Output channel (out_valid/out_ready/out_*) carries one result word for
//   each vertex's fourth word and for each zero header; other words give none.
//   Path: an accepted word is held in the input register, then its result
//   in the result register.
//   Throughput: one command word per cycle, sustained while out_ready is high;
//   the single stage of decode and corner arithmetic sets this.
//   Receiver stall: a waiting result stays in the result register and one
//   more word is held in the input register; in_ready drops only when both
//   are occupied.
//   Reset (rst_n low, synchronous): both registers empty, decoder expects a
//   header, vertex counter and overflow flag cleared.
// ----------------------------------------------------------------------------
module strip_fan_triangle_assembler import sfta_pkg::*; #(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [WORD_W-1:0]  in_cmd_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_vertex_valid,
  output logic [IDX_W-1:0]          out_vertex_index,
  output logic [FIELD_W-1:0]        out_position_index,
  output logic [FIELD_W-1:0]        out_normal_index,
  output logic signed [WORD_W-1:0]  out_tex_s,
  output logic signed [WORD_W-1:0]  out_tex_t,
  output logic                      out_triangle_valid,
  output logic [IDX_W-1:0]          out_corner_a,
  output logic [IDX_W-1:0]          out_corner_b,
  output logic [IDX_W-1:0]          out_corner_c,
  output logic                      out_mesh_end,
  output logic                      out_index_overflow
);

  logic                     word_valid;
  logic signed [WORD_W-1:0] word;
  logic                     adv;
  logic                     res_valid;
  logic                     out_full;
  sfta_result_t             core_res;
  sfta_result_t             res;

  // Held word moves on when the result register can take a word
  assign adv = word_valid && (!out_full || out_ready);

  sfta_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_cmd_word),
    .adv        (adv),
    .word_valid (word_valid),
    .word       (word)
  );

  sfta_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .word      (word),
    .res_valid (res_valid),
    .res       (core_res)
  );

  sfta_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .load_res  (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .full      (out_full),
    .res       (res)
  );

  // Break the result word out onto its ports
  assign out_vertex_valid   = res.vertex_valid;
  assign out_vertex_index   = res.vertex_index;
  assign out_position_index = res.position_index;
  assign out_normal_index   = res.normal_index;
  assign out_tex_s          = res.tex_s;
  assign out_tex_t          = res.tex_t;
  assign out_triangle_valid = res.triangle_valid;
  assign out_corner_a       = res.corner_a;
  assign out_corner_b       = res.corner_b;
  assign out_corner_c       = res.corner_c;
  assign out_mesh_end       = res.mesh_end;
  assign out_index_overflow = res.index_overflow;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strip/fan triangle assembler. A queue of command
// words (directed headers and vertices, random strips and fans, one long fan
// and strip with no idling, then six short primitives) feeds a valid/ready
// driver. Each accepted word goes through a local primitive-assembly model,
// and the monitor checks every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sfta_pkg::*;

  localparam int unsigned INDEX_BITS = INDEX_BITS_DEFAULT;
  localparam int unsigned RANDOM_WORDS = 720;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT = 23;
  localparam int unsigned REPORT_MAX = 10;

  // position of a word inside one vertex record
  typedef enum logic [1:0] {
    PH_POS,
    PH_NRM,
    PH_S,
    PH_T
  } vertex_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [WORD_W-1:0] in_cmd_word = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  sfta_result_t             seen_result;

  // words still to send, results still owed by the block
  logic [WORD_W-1:0] cmd_words[$];
  sfta_result_t      owed_results[$];

  // no idling on either side while set
  logic        calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;

  // assembler model state
  vertex_word_t          asm_phase;
  logic [16:0]           asm_left;
  logic                  asm_fan;
  logic [IDX_W-1:0]      asm_nth;
  logic [INDEX_BITS-1:0] asm_count;
  logic [FIELD_W-1:0]    asm_pos;
  logic [FIELD_W-1:0]    asm_nrm;
  logic [WORD_W-1:0]     asm_s;
  logic                  asm_ovf;

  strip_fan_triangle_assembler #(
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd_word       (in_cmd_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_valid  (seen_result.vertex_valid),
    .out_vertex_index  (seen_result.vertex_index),
    .out_position_index(seen_result.position_index),
    .out_normal_index  (seen_result.normal_index),
    .out_tex_s         (seen_result.tex_s),
    .out_tex_t         (seen_result.tex_t),
    .out_triangle_valid(seen_result.triangle_valid),
    .out_corner_a      (seen_result.corner_a),
    .out_corner_b      (seen_result.corner_b),
    .out_corner_c      (seen_result.corner_c),
    .out_mesh_end      (seen_result.mesh_end),
    .out_index_overflow(seen_result.index_overflow)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Assembler model: consume one command word, queue the result it causes
  function automatic void assemble_word(input logic [WORD_W-1:0] w);
    sfta_result_t     r;
    logic [IDX_W-1:0] idx;
    r = '0;
    if (asm_left == '0) begin
      if (w == '0) begin
        // zero header ends the mesh
        r.mesh_end = 1'b1;
        r.index_overflow = asm_ovf;
        owed_results.push_back(r);
      end else begin
        // negative count starts a fan, positive a strip
        asm_fan = w[WORD_W-1];
        asm_left = w[WORD_W-1] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
        asm_nth = '0;
        asm_phase = PH_POS;
      end
    end else begin
      unique case (asm_phase)
        PH_POS: begin
          asm_pos = w[FIELD_W-1:0];
          asm_phase = PH_NRM;
        end
        PH_NRM: begin
          asm_nrm = w[FIELD_W-1:0];
          asm_phase = PH_S;
        end
        PH_S: begin
          asm_s = w;
          asm_phase = PH_T;
        end
        default: begin
          // last word of the vertex: emit it
          asm_phase = PH_POS;
          idx = IDX_W'(asm_count);
          if (asm_count != '1) asm_count = asm_count + 1'b1;
          else asm_ovf = 1'b1;
          if (asm_nth >= TRI_START) begin
            r.triangle_valid = 1'b1;
            r.corner_c = idx;
            if (asm_fan) begin
              r.corner_a = idx - asm_nth;
              r.corner_b = idx - 1'b1;
            end else if (!asm_nth[0]) begin
              r.corner_a = idx - 2'd2;
              r.corner_b = idx - 1'b1;
            end else begin
              // odd vertex of a strip flips the winding
              r.corner_a = idx - 1'b1;
              r.corner_b = idx - 2'd2;
            end
          end
          if (asm_nth != '1) asm_nth = asm_nth + 1'b1;
          asm_left = asm_left - 1'b1;
          r.vertex_valid = 1'b1;
          r.vertex_index = idx;
          r.position_index = asm_pos;
          r.normal_index = asm_nrm;
          r.tex_s = asm_s;
          r.tex_t = w;
          r.index_overflow = asm_ovf;
          owed_results.push_back(r);
        end
      endcase
    end
  endfunction

  function automatic string fmt_result(input sfta_result_t r);
    return $sformatf({"v=%0b idx=%h pos=%h nrm=%h s=%h t=%h tri=%0b a=%h b=%h c=%h ",
                      "end=%0b ovf=%0b"}, r.vertex_valid, r.vertex_index,
                     r.position_index, r.normal_index, r.tex_s, r.tex_t,
                     r.triangle_valid, r.corner_a, r.corner_b, r.corner_c,
                     r.mesh_end, r.index_overflow);
  endfunction

  // Field word, biased toward the extremes
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return WORD_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic push_vertex(input logic [WORD_W-1:0] pos, input logic [WORD_W-1:0] nrm,
                             input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] t);
    cmd_words.push_back(pos);
    cmd_words.push_back(nrm);
    cmd_words.push_back(s);
    cmd_words.push_back(t);
  endtask

  // header word followed by that many random vertices
  task automatic push_primitive(input logic [WORD_W-1:0] header, input int unsigned nverts);
    cmd_words.push_back(header);
    repeat (nverts) push_vertex(rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // Driver: one word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) assemble_word(in_cmd_word);
      if (!in_valid || in_ready) begin
        if (cmd_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_cmd_word <= cmd_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("result %0d unexpected: %s", results_seen, fmt_result(seen_result));
          mismatches <= mismatches + 1;
        end else if (seen_result !== owed_results[0]) begin
          if (mismatches < REPORT_MAX) begin
            $display("result %0d expected: %s", results_seen, fmt_result(owed_results[0]));
            $display("result %0d actual:   %s", results_seen, fmt_result(seen_result));
          end
          mismatches <= mismatches + 1;
          void'(owed_results.pop_front());
        end else begin
          void'(owed_results.pop_front());
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: no handshake for too long while work is pending
  always @(posedge clk) begin
    if (rst_n && (in_valid || cmd_words.size() != 0 || owed_results.size() != 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready))
      stall_cycles <= stall_cycles + 1;
    else
      stall_cycles <= 0;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", stall_cycles);
      $display("[strip_fan_triangle_assembler] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_words.size() != 0 || in_valid || owed_results.size() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned n;

    asm_phase = PH_POS;
    asm_left = '0;
    asm_fan = 1'b0;
    asm_nth = '0;
    asm_count = '0;
    asm_pos = '0;
    asm_nrm = '0;
    asm_s = '0;
    asm_ovf = 1'b0;

    // mesh end straight out of reset
    cmd_words.push_back(16'h0000);
    // strip of four: first triangle, then flipped winding
    cmd_words.push_back(16'h0004);
    push_vertex(16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF);
    push_vertex(16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000);
    push_vertex(16'h0001, 16'h4000, 16'hFFFF, 16'h0000);
    push_vertex(16'hC000, 16'h7FFE, 16'h0001, 16'hFFFF);
    cmd_words.push_back(16'h0000);
    // fan of one vertex: no triangle
    cmd_words.push_back(16'hFFFF);
    push_vertex(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA);

    // random strips and fans, mostly short, some mesh ends between them
    while (cmd_words.size() < RANDOM_WORDS) begin
      if ($urandom_range(5) == 0) cmd_words.push_back(16'h0000);
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
      if ($urandom_range(1) == 1) push_primitive(WORD_W'(-int'(n)), n);
      else push_primitive(WORD_W'(n), n);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // long fan and long strip back to back, no idling on either side
    wait_drained();
    calm = 1'b1;
    push_primitive(16'hFFD8, 40);
    push_primitive(16'h0029, 41);
    cmd_words.push_back(16'h0000);
    wait_drained();
    calm = 1'b0;

    // a few more short primitives
    repeat (6) begin
      n = $urandom_range(5, 1);
      push_primitive(($urandom_range(1) == 1) ? WORD_W'(-int'(n)) : WORD_W'(n), n);
    end
    cmd_words.push_back(16'h0000);
    wait_drained();

    // let any stray result surface
    repeat (10) @(posedge clk);
    if (owed_results.size() != 0)
      $display("%0d results never arrived", owed_results.size());
    if (mismatches == 0 && owed_results.size() == 0)
      $display("[strip_fan_triangle_assembler] OK");
    else
      $display("[strip_fan_triangle_assembler] ERROR");
    $finish;
  end

endmodule
